/* rtl/fpa_pkg.sv */
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

	localparam int unsigned FRACTION_BITS = 8;
	localparam int unsigned OP_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IN_TDATA_W = 72;
	localparam int unsigned OUT_TDATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MIN = 4'd4,
		OP_MAX = 4'd5,
		OP_INC = 4'd6,
		OP_DEC = 4'd7,
		OP_ITF = 4'd8,
		OP_FTI = 4'd9
	} op_t;

	localparam int unsigned OUT_LT_BIT = 32;
	localparam int unsigned OUT_EQ_BIT = 33;
	localparam int unsigned OUT_GT_BIT = 34;
	localparam int unsigned OUT_DE_BIT = 35;

endpackage

/* rtl/fixed_point_alu.sv */
// Pipelined signed fixed-point ALU with a bit-per-stage restoring divider.
//
// channel  dir  tdata fields (low bit up)                         width
// s_axis   in   op[3:0] operand_a[35:4] operand_b[67:36] pad        72
// m_axis   out  result_value[31:0] less_than equal_to greater_than
//               divide_error pad                                    40
//
// Every op passes through every stage; one transaction per cycle while m_axis_tready is high.
// The depth is set by the divider: one quotient bit per stage, 32+FRACTION_BITS.
// arst_n clears all stage valid bits; payload registers are not reset.
// Each stage holds while its successor is full and stalled; empty stages fill.
module fixed_point_alu #(
	parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [fpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // op, operand_a, operand_b
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [fpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // result_value, lt, eq, gt, div err
);

	localparam int unsigned DW = fpa_pkg::DATA_W;
	localparam int unsigned NW = DW + FRACTION_BITS;
	localparam int unsigned NSTG = NW + 3;

	typedef struct packed {
		fpa_pkg::op_t    op;
		logic [DW-1:0]   res;
		logic            lt;
		logic            eq;
		logic            gt;
		logic            neg;
		logic            derr;
		logic [DW-1:0]   ma;
		logic [DW-1:0]   mb;
		logic [NW-1:0]   num;
		logic [DW:0]     rem;
	} stage_t;

	stage_t          pipe_s [NSTG];
	logic            vld_s  [NSTG];
	stage_t          nxt    [NSTG];
	logic            rdy    [NSTG+1];

	logic [fpa_pkg::OP_W-1:0] in_op;
	logic signed [DW-1:0]     in_a;
	logic signed [DW-1:0]     in_b;
	logic [2*DW-1:0]          prod;
	logic [2*DW-1:0]          prod_rnd;
	logic [DW-1:0]            fti_mag;
	logic [DW+1:0]            rem2;
	logic [DW-1:0]            qround;

	assign in_op = s_axis_tdata[fpa_pkg::OP_W-1:0];
	assign in_a  = s_axis_tdata[fpa_pkg::OP_W +: DW];
	assign in_b  = s_axis_tdata[fpa_pkg::OP_W+DW +: DW];

	always_comb begin
		rdy[NSTG] = m_axis_tready;
		for (int i = NSTG-1; i >= 0; i--) begin
			rdy[i] = !vld_s[i] || rdy[i+1];
		end
	end

	assign s_axis_tready = rdy[0];

	always_comb begin
		// stage 0: decode, compare, simple ops, magnitudes
		nxt[0] = '0;
		nxt[0].op = fpa_pkg::op_t'(in_op);
		nxt[0].lt = in_a < in_b;
		nxt[0].eq = in_a == in_b;
		nxt[0].gt = in_a > in_b;
		nxt[0].ma = in_a[DW-1] ? DW'(-in_a) : DW'(in_a);
		nxt[0].mb = in_b[DW-1] ? DW'(-in_b) : DW'(in_b);
		nxt[0].neg = in_a[DW-1] ^ in_b[DW-1];
		nxt[0].derr = (in_op == fpa_pkg::OP_DIV) && (in_b == '0);
		fti_mag = nxt[0].ma >> FRACTION_BITS;
		case (in_op)
			fpa_pkg::OP_ADD: nxt[0].res = in_a + in_b;
			fpa_pkg::OP_SUB: nxt[0].res = in_a - in_b;
			fpa_pkg::OP_MIN: nxt[0].res = (in_a < in_b) ? in_a : in_b;
			fpa_pkg::OP_MAX: nxt[0].res = (in_a > in_b) ? in_a : in_b;
			fpa_pkg::OP_INC: nxt[0].res = in_a + DW'(1);
			fpa_pkg::OP_DEC: nxt[0].res = in_a - DW'(1);
			fpa_pkg::OP_ITF: nxt[0].res = in_a << FRACTION_BITS;
			fpa_pkg::OP_FTI: nxt[0].res = in_a[DW-1] ? -fti_mag : fti_mag;
			default:         nxt[0].res = '0;
		endcase

		// stage 1: magnitude product, divider load; the divisor stays for non-multiplies
		nxt[1] = pipe_s[0];
		prod = {{DW{1'b0}}, pipe_s[0].ma} * {{DW{1'b0}}, pipe_s[0].mb};
		nxt[1].num = {pipe_s[0].ma, {FRACTION_BITS{1'b0}}};
		nxt[1].rem = '0;
		if (pipe_s[0].op == fpa_pkg::OP_MUL) begin
			nxt[1].ma = prod[DW-1:0];
			nxt[1].mb = prod[2*DW-1:DW];
		end

		// stage 2..NW+1: one quotient bit per stage; stage 2 also rounds the product
		for (int k = 2; k <= NW+1; k++) begin
			logic [DW:0] sh;
			nxt[k] = pipe_s[k-1];
			sh = {pipe_s[k-1].rem[DW-1:0], pipe_s[k-1].num[NW-1]};
			if (sh >= {1'b0, pipe_s[k-1].mb}) begin
				nxt[k].rem = sh - {1'b0, pipe_s[k-1].mb};
				nxt[k].num = {pipe_s[k-1].num[NW-2:0], 1'b1};
			end else begin
				nxt[k].rem = sh;
				nxt[k].num = {pipe_s[k-1].num[NW-2:0], 1'b0};
			end
		end
		prod_rnd = ({pipe_s[1].mb, pipe_s[1].ma} + (64'(1) << (FRACTION_BITS-1)))
			>> FRACTION_BITS;
		if (pipe_s[1].op == fpa_pkg::OP_MUL) begin
			nxt[2].res = pipe_s[1].neg ? -prod_rnd[DW-1:0] : prod_rnd[DW-1:0];
		end

		// last stage: divide rounding and sign
		nxt[NSTG-1] = pipe_s[NSTG-2];
		rem2 = {pipe_s[NSTG-2].rem, 1'b0};
		qround = pipe_s[NSTG-2].num[DW-1:0] +
			DW'(rem2 >= {2'b0, pipe_s[NSTG-2].mb});
		if (pipe_s[NSTG-2].op == fpa_pkg::OP_DIV) begin
			if (pipe_s[NSTG-2].derr) begin
				nxt[NSTG-1].res = '0;
			end else begin
				nxt[NSTG-1].res = pipe_s[NSTG-2].neg ? -qround : qround;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTG; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (rdy[i]) begin
					vld_s[i] <= (i == 0) ? s_axis_tvalid : vld_s[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NSTG; i++) begin
			if (rdy[i]) begin
				pipe_s[i] <= nxt[i];
			end
		end
	end

	assign m_axis_tvalid = vld_s[NSTG-1];
	assign m_axis_tdata = {4'b0, pipe_s[NSTG-1].derr, pipe_s[NSTG-1].gt,
		pipe_s[NSTG-1].eq, pipe_s[NSTG-1].lt, pipe_s[NSTG-1].res};

endmodule

/* rtl/fpa_checker.sv */
// Port-level checks for the fixed-point ALU, bound to the top level.
module fpa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [fpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot(m_axis_tdata[fpa_pkg::OUT_GT_BIT:fpa_pkg::OUT_LT_BIT]))
		else $error("compare flags not one-hot");

	a_derr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[fpa_pkg::OUT_DE_BIT] |->
		m_axis_tdata[fpa_pkg::DATA_W-1:0] == '0)
		else $error("divide error with nonzero result");

	a_derr_eq: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[fpa_pkg::OUT_DE_BIT] |->
		!m_axis_tdata[fpa_pkg::OUT_EQ_BIT] || m_axis_tdata[fpa_pkg::DATA_W-1:0] == '0)
		else $error("divide error result inconsistent");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
